FILE: hdl/hsr_pkg.sv
package hsr_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int TOL_W  = 16;
  localparam int ITER_W = 7;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_ITER  = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RESET = 16'd1;
  localparam logic [ITER_W-1:0] CAP_RESET = 7'd32;
  localparam logic [ITER_W-1:0] CAP_LIMIT = 7'd64;

endpackage

FILE: hdl/hsr_div.sv
module hsr_div #(
  parameter int DATA_WIDTH = hsr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = hsr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [DATA_WIDTH-1:0] num,
  input  logic [DATA_WIDTH-1:0] den,
  output logic                  fin,
  output logic [DATA_WIDTH-1:0] quot
);

  localparam int STEPS = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic                  run;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] num_sh;
  logic [DATA_WIDTH-1:0] q;
  logic                  sat;

  logic [DATA_WIDTH:0]   rem_sh;
  logic                  ge;
  logic [DATA_WIDTH:0]   rem_diff;

  assign rem_sh   = {rem, num_sh[DATA_WIDTH-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};
  assign quot     = sat ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem    <= '0;
      num_sh <= num;
      q      <= '0;
      sat    <= 1'b0;
    end else if (run) begin
      rem    <= ge ? rem_diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      num_sh <= {num_sh[DATA_WIDTH-2:0], 1'b0};
      if (!sat) begin
        if (q[DATA_WIDTH-1]) begin
          sat <= 1'b1;
        end else begin
          q <= {q[DATA_WIDTH-2:0], ge};
        end
      end
    end
  end

endmodule

FILE: hdl/heron_square_root.sv
// Heron square root, unsigned fixed point, start guess 2.0.
// A request runs n Heron steps (n = 1..64). A step divides the radicand by the guess
// in the bit-serial divider, then sums, halves, takes the difference and checks it;
// the divider is skipped when the guess is zero.
// Throughput: one request at a time; busy is high until done pulses, and the next
// request is taken in the done cycle. Synchronous reset: idle, tolerance = 1, max_iterations = 32.
module heron_square_root #(
  parameter int DATA_WIDTH = hsr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = hsr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [DATA_WIDTH-1:0]       radicand,
  output logic                        done,
  output logic [DATA_WIDTH-1:0]       root,
  output logic [hsr_pkg::ITER_W-1:0]  iterations,
  output logic                        converged,
  input  logic                        cfg_write,
  input  logic [hsr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [hsr_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_DIFF   = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;

  localparam int SW = DATA_WIDTH + FRAC_BITS + 1;
  localparam logic [SW-1:0] START_WIDE = SW'(2) << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] START_GUESS = START_WIDE[DATA_WIDTH-1:0];

  logic [2:0]                   state;
  logic [hsr_pkg::TOL_W-1:0]    tolerance;
  logic [hsr_pkg::ITER_W-1:0]   max_iterations;
  logic [hsr_pkg::ITER_W-1:0]   cap;
  logic [hsr_pkg::ITER_W-1:0]   step_count;
  logic [DATA_WIDTH-1:0]        x;
  logic [DATA_WIDTH-1:0]        guess;
  logic [DATA_WIDTH-1:0]        q;
  logic [DATA_WIDTH-1:0]        next;
  logic [DATA_WIDTH-1:0]        diff;

  logic                         div_go;
  logic                         div_fin;
  logic [DATA_WIDTH-1:0]        div_quot;
  logic [DATA_WIDTH:0]          sum;
  logic [hsr_pkg::ITER_W-1:0]   cap_next;

  assign busy = state != S_IDLE;
  assign div_go = (state == S_LAUNCH) && (guess != '0);
  assign sum = {1'b0, q} + {1'b0, guess};

  always_comb begin
    priority if (max_iterations == '0) begin
      cap_next = hsr_pkg::ITER_W'(1);
    end else if (max_iterations > hsr_pkg::CAP_LIMIT) begin
      cap_next = hsr_pkg::CAP_LIMIT;
    end else begin
      cap_next = max_iterations;
    end
  end

  hsr_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (x),
    .den (guess),
    .fin (div_fin),
    .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= hsr_pkg::TOL_RESET;
      max_iterations <= hsr_pkg::CAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hsr_pkg::REG_TOLERANCE: tolerance <= cfg_data;
        hsr_pkg::REG_MAX_ITER:  max_iterations <= cfg_data[hsr_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      step_count <= '0;
      guess      <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x          <= radicand;
            cap        <= cap_next;
            guess      <= START_GUESS;
            step_count <= '0;
            state      <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          if (guess == '0) begin
            q     <= '0;
            state <= S_SUM;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_fin) begin
            q     <= div_quot;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          next       <= sum[DATA_WIDTH:1];
          step_count <= step_count + 1'b1;
          state      <= S_DIFF;
        end
        S_DIFF: begin
          diff  <= (guess >= next) ? guess - next : next - guess;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (diff < DATA_WIDTH'(tolerance)) begin
            converged  <= 1'b1;
            root       <= next;
            iterations <= step_count;
            done       <= 1'b1;
            guess      <= next;
            state      <= S_IDLE;
          end else if (step_count >= cap) begin
            converged  <= 1'b0;
            root       <= next;
            iterations <= step_count;
            done       <= 1'b1;
            guess      <= next;
            state      <= S_IDLE;
          end else begin
            guess <= next;
            state <= S_LAUNCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/hsr_chk.sv
module hsr_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [hsr_pkg::ITER_W-1:0] iterations
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe without a request in flight");

  a_idle_no_done: assert property (@(posedge clk) disable iff (rst)
    (!busy && !done) |=> !done)
    else $error("result strobe out of idle");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (iterations != '0) && (iterations <= hsr_pkg::CAP_LIMIT))
    else $error("iteration count out of range");

endmodule

bind heron_square_root hsr_chk u_hsr_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .iterations(iterations)
);
